// ===== sv/kqa_pkg.sv =====
package kqa_pkg;

    localparam int NUM_DEVICES = 2;
    localparam int NKEYS       = 6;
    localparam int NARROWS     = 4;
    localparam int NARMED      = NUM_DEVICES * NARROWS;
    localparam int TREE_LEAVES = 2 ** $clog2(NARMED);

    localparam logic [15:0] PERIOD_RESET = 16'd700;
    localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

    // raw event types and sync subtypes
    localparam logic [15:0] EV_SYN       = 16'd0;
    localparam logic [15:0] EV_KEY       = 16'd1;
    localparam logic [15:0] SYNC_MARK    = 16'd0;
    localparam logic [15:0] SYNC_OVERRUN = 16'd3;

    localparam logic [31:0] VAL_RELEASE = 32'd0;
    localparam logic [31:0] VAL_PRESS   = 32'd1;

    localparam logic [15:0] CODE_UP    = 16'd103;
    localparam logic [15:0] CODE_DOWN  = 16'd108;
    localparam logic [15:0] CODE_LEFT  = 16'd105;
    localparam logic [15:0] CODE_RIGHT = 16'd106;
    localparam logic [15:0] CODE_OK_A  = 16'd352;
    localparam logic [15:0] CODE_OK_B  = 16'd28;
    localparam logic [15:0] CODE_BACK  = 16'd158;

    typedef enum logic [1:0] {
        OP_RAW    = 2'd0,
        OP_TICK   = 2'd1,
        OP_RESUME = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_UP    = 3'd1,
        KEY_DN    = 3'd2,
        KEY_LT    = 3'd3,
        KEY_RT    = 3'd4,
        KEY_OK    = 3'd5,
        KEY_BACK  = 3'd6
    } key_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic        device;
        logic [15:0] event_type;
        logic [15:0] event_code;
        logic [31:0] event_value;
        logic [31:0] now_ms;
        logic [31:0] deadline_in;
    } request_t;

    function automatic key_t code_to_key(input logic [15:0] code);
        key_t k;
        case (code)
            CODE_UP:    k = KEY_UP;
            CODE_DOWN:  k = KEY_DN;
            CODE_LEFT:  k = KEY_LT;
            CODE_RIGHT: k = KEY_RT;
            CODE_OK_A:  k = KEY_OK;
            CODE_OK_B:  k = KEY_OK;
            CODE_BACK:  k = KEY_BACK;
            default:    k = KEY_NONE;
        endcase
        return k;
    endfunction

endpackage

// ===== sv/kqa_ifs.sv =====
interface kqa_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic        device;
    logic [15:0] event_type;
    logic [15:0] event_code;
    logic signed [31:0] event_value;
    logic [31:0] now_ms;
    logic [31:0] deadline_in;

    modport source (
        output valid, operation, device, event_type, event_code, event_value,
               now_ms, deadline_in,
        input  ready
    );
    modport sink (
        input  valid, operation, device, event_type, event_code, event_value,
               now_ms, deadline_in,
        output ready
    );
endinterface

interface kqa_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  key_out;
    logic [31:0] next_due_ms;

    modport source (output valid, key_out, next_due_ms, input ready);
    modport sink   (input valid, key_out, next_due_ms, output ready);
endinterface

// ===== sv/key_event_qualifier_autorepeat.sv =====
// Key event qualifier with auto-repeat.
//
// evt carries one request per accepted valid/ready handshake: a raw device
// event, a repeat tick or a resume. res returns exactly one result per
// request, in order: the emitted logical key and the earliest repeat time of
// any held arrow, capped by the request's deadline. cfg_wr_en/cfg_wr_data
// write the repeat period in milliseconds; write it only while idle.
//
// Pipeline: input register -> qualify/update stage -> minimum stage -> output
// register. A request passes the input, middle and output registers, and a new
// request can be taken every cycle while res does not stall. The per-cycle work
// is the key decode, one 32-bit saturating add, eight parallel compares with a
// priority pick, and a compare tree over the eight armed repeat times.
//
// Reset clears held flags, overflow waits and the pipeline, and loads the
// period with 700 ms. Repeat times come up undefined; they are only read for
// held arrows, whose press always writes them first.
//
// When res stalls, each stage holds and the stages behind it keep filling;
// evt.ready drops only once all three pipeline registers hold requests.
module key_event_qualifier_autorepeat (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    kqa_in_if.sink      evt,
    kqa_out_if.source   res
);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [15:0] period_reg;
    logic        held_reg  [kqa_pkg::NUM_DEVICES][kqa_pkg::NKEYS];
    logic        held_next [kqa_pkg::NUM_DEVICES][kqa_pkg::NKEYS];
    logic        wait_reg  [kqa_pkg::NUM_DEVICES];
    logic        wait_next [kqa_pkg::NUM_DEVICES];
    logic [31:0] rtime_reg [kqa_pkg::NUM_DEVICES][kqa_pkg::NARROWS];

    // pipeline registers
    kqa_pkg::request_t in_reg;
    logic              in_valid_reg;
    kqa_pkg::key_t     mid_key_reg;
    kqa_pkg::key_t     key_next;
    logic [31:0]       mid_deadline_reg;
    logic              mid_valid_reg;
    kqa_pkg::key_t     out_key_reg;
    logic [31:0]       out_due_reg;
    logic              out_valid_reg;

    // stage enables: a stage loads when it is empty or its content moves on
    logic out_en;
    logic mid_en;
    logic in_en;

    assign out_en    = !out_valid_reg || res.ready;
    assign mid_en    = !mid_valid_reg || out_en;
    assign in_en     = !in_valid_reg  || mid_en;
    assign evt.ready = in_en;

    logic advance_in;
    assign advance_in = in_valid_reg && mid_en;

    // ---------------------------------------------------------------
    // Qualify/update stage
    // ---------------------------------------------------------------
    logic                    dev_ok;
    kqa_pkg::key_t           code_key;
    logic [2:0]              key_idx;
    logic [32:0]             arm_sum;
    logic [31:0]             arm_time;
    logic                    rt_we;
    logic                    rt_dev;
    logic [1:0]              rt_idx;
    logic                    tick_found;

    assign dev_ok   = 32'(in_reg.device) < 32'(kqa_pkg::NUM_DEVICES);
    assign code_key = kqa_pkg::code_to_key(in_reg.event_code);
    assign key_idx  = 3'(code_key - 3'd1);

    // saturate the re-arm time instead of wrapping
    assign arm_sum  = {1'b0, in_reg.now_ms} + {17'd0, period_reg};
    assign arm_time = arm_sum[32] ? kqa_pkg::TIME_MAX : arm_sum[31:0];

    always_comb
    begin
        held_next  = held_reg;
        wait_next  = wait_reg;
        key_next   = kqa_pkg::KEY_NONE;
        rt_we      = 1'b0;
        rt_dev     = in_reg.device;
        rt_idx     = key_idx[1:0];
        tick_found = 1'b0;

        case (in_reg.operation)
            kqa_pkg::OP_RAW:
            begin
                if (dev_ok)
                begin
                    if (in_reg.event_type == kqa_pkg::EV_SYN &&
                        in_reg.event_code == kqa_pkg::SYNC_OVERRUN)
                    begin
                        // queue overflow: drop everything held and wait
                        for (int k = 0; k < kqa_pkg::NKEYS; k++)
                        begin
                            held_next[in_reg.device][k] = 1'b0;
                        end
                        wait_next[in_reg.device] = 1'b1;
                    end
                    else if (wait_reg[in_reg.device])
                    begin
                        if (in_reg.event_type == kqa_pkg::EV_SYN &&
                            in_reg.event_code == kqa_pkg::SYNC_MARK)
                        begin
                            wait_next[in_reg.device] = 1'b0;
                        end
                    end
                    else if (in_reg.event_type == kqa_pkg::EV_KEY &&
                             code_key != kqa_pkg::KEY_NONE)
                    begin
                        if (in_reg.event_value == kqa_pkg::VAL_RELEASE)
                        begin
                            held_next[in_reg.device][key_idx] = 1'b0;
                        end
                        else if (in_reg.event_value == kqa_pkg::VAL_PRESS &&
                                 !held_reg[in_reg.device][key_idx])
                        begin
                            held_next[in_reg.device][key_idx] = 1'b1;
                            key_next = code_key;
                            rt_we    = (code_key <= kqa_pkg::KEY_RT);
                        end
                    end
                end
            end
            kqa_pkg::OP_TICK:
            begin
                // first due held arrow in device-then-key order
                for (int d = 0; d < kqa_pkg::NUM_DEVICES; d++)
                begin
                    for (int k = 0; k < kqa_pkg::NARROWS; k++)
                    begin
                        if (!tick_found && held_reg[d][k] &&
                            in_reg.now_ms >= rtime_reg[d][k])
                        begin
                            tick_found = 1'b1;
                            rt_we      = 1'b1;
                            rt_dev     = 1'(d);
                            rt_idx     = 2'(k);
                            key_next   = kqa_pkg::key_t'(3'(k + 1));
                        end
                    end
                end
            end
            kqa_pkg::OP_RESUME:
            begin
                for (int d = 0; d < kqa_pkg::NUM_DEVICES; d++)
                begin
                    for (int k = 0; k < kqa_pkg::NKEYS; k++)
                    begin
                        held_next[d][k] = 1'b0;
                    end
                end
            end
            default:
            begin
                key_next = kqa_pkg::KEY_NONE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Minimum stage: reads state as left by the request in mid
    // ---------------------------------------------------------------
    logic [31:0] node [1:2*kqa_pkg::TREE_LEAVES-1];
    logic [31:0] due_next;

    always_comb
    begin
        for (int i = 0; i < kqa_pkg::TREE_LEAVES; i++)
        begin
            node[kqa_pkg::TREE_LEAVES + i] = kqa_pkg::TIME_MAX;
        end
        for (int d = 0; d < kqa_pkg::NUM_DEVICES; d++)
        begin
            for (int k = 0; k < kqa_pkg::NARROWS; k++)
            begin
                if (held_reg[d][k])
                begin
                    node[kqa_pkg::TREE_LEAVES + d * kqa_pkg::NARROWS + k] = rtime_reg[d][k];
                end
            end
        end
        for (int i = kqa_pkg::TREE_LEAVES - 1; i >= 1; i--)
        begin
            node[i] = (node[2*i] < node[2*i+1]) ? node[2*i] : node[2*i+1];
        end
        due_next = (node[1] < mid_deadline_reg) ? node[1] : mid_deadline_reg;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= kqa_pkg::PERIOD_RESET;
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int d = 0; d < kqa_pkg::NUM_DEVICES; d++)
            begin
                wait_reg[d] <= 1'b0;
                for (int k = 0; k < kqa_pkg::NKEYS; k++)
                begin
                    held_reg[d][k] <= 1'b0;
                end
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (in_en)
            begin
                in_valid_reg <= evt.valid;
            end
            if (mid_en)
            begin
                mid_valid_reg <= in_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= mid_valid_reg;
            end
            // commit state only as the request leaves the input register
            if (advance_in)
            begin
                held_reg <= held_next;
                wait_reg <= wait_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_en && evt.valid)
        begin
            in_reg.operation   <= evt.operation;
            in_reg.device      <= evt.device;
            in_reg.event_type  <= evt.event_type;
            in_reg.event_code  <= evt.event_code;
            in_reg.event_value <= evt.event_value;
            in_reg.now_ms      <= evt.now_ms;
            in_reg.deadline_in <= evt.deadline_in;
        end
        if (advance_in)
        begin
            mid_key_reg      <= key_next;
            mid_deadline_reg <= in_reg.deadline_in;
            if (rt_we)
            begin
                rtime_reg[rt_dev][rt_idx] <= arm_time;
            end
        end
        if (mid_valid_reg && out_en)
        begin
            out_key_reg <= mid_key_reg;
            out_due_reg <= due_next;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.key_out     = out_key_reg;
    assign res.next_due_ms = out_due_reg;

endmodule

// ===== sv/kqa_checker.sv =====
module kqa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  key_out,
    input logic [31:0] next_due_ms
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(key_out) && $stable(next_due_ms))
        else $error("stalled result changed");

    // a request accepted with a free output path reaches the result port
    assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready ##1 res_ready ##1 res_ready) |=> res_valid)
        else $error("result missing after free-running request");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> key_out <= kqa_pkg::KEY_BACK)
        else $error("key code out of range");

endmodule

bind key_event_qualifier_autorepeat kqa_checker u_kqa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt.valid),
    .evt_ready   (evt.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .key_out     (res.key_out),
    .next_due_ms (res.next_due_ms)
);

// ===== tb/tb_key_event_qualifier_autorepeat.sv =====
`timescale 1ns / 1ps

module tb_key_event_qualifier_autorepeat;

    // Operation code that the block must treat as a no-op.
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    // Device-side autorepeat value; the block has to ignore it.
    localparam logic [31:0] VAL_AUTOREPEAT = 32'd2;
    localparam int          NDIR           = 27;
    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          HOLD_OFF_LEN   = 150;

    localparam logic [15:0] KEY_CODES [7] = '{
        kqa_pkg::CODE_UP, kqa_pkg::CODE_DOWN, kqa_pkg::CODE_LEFT, kqa_pkg::CODE_RIGHT,
        kqa_pkg::CODE_OK_A, kqa_pkg::CODE_OK_B, kqa_pkg::CODE_BACK
    };

    typedef struct {
        kqa_pkg::key_t key;
        logic [31:0]   next_due;
    } key_report_t;

    // One line of the directed table. Where typed is set, key and due are the
    // hand-worked result; otherwise the predictor decides.
    typedef struct {
        kqa_pkg::request_t req;
        bit                typed;
        kqa_pkg::key_t     key;
        logic [31:0]       due;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    kqa_in_if  evt_if ();
    kqa_out_if res_if ();

    key_event_qualifier_autorepeat DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .evt         (evt_if),
        .res         (res_if)
    );

    // ------------------------------------------------------------------
    // Predictor state: a private copy of what the block should hold.
    // ------------------------------------------------------------------
    logic [15:0] period_ms = kqa_pkg::PERIOD_RESET;
    bit          held_key       [kqa_pkg::NUM_DEVICES][kqa_pkg::NKEYS];
    bit          waiting_report [kqa_pkg::NUM_DEVICES];
    logic [31:0] due_at_ms      [kqa_pkg::NUM_DEVICES][kqa_pkg::NARROWS];

    // Results still owed by the block, oldest first.
    key_report_t key_reports_q [$];

    int          fail_count  = 0;
    int          cycle_count = 0;
    int          src_idle    = 15;   // percent of cycles the request side idles
    int          snk_idle    = 47;   // percent of cycles the result side stalls
    bit          hold_off_req = 1'b0;
    logic [31:0] wall_ms = 32'd0;    // running notion of "now" for random traffic
    key_report_t want;

    // Saturating re-arm: now plus the period, pinned at the top of the range.
    function automatic logic [31:0] rearm_time(input logic [31:0] now);
        logic [32:0] sum;
        sum = {1'b0, now} + {17'b0, period_ms};
        return sum[32] ? kqa_pkg::TIME_MAX : sum[31:0];
    endfunction

    // Advance the predictor by one request and return the result it owes.
    function automatic key_report_t qualify_event(input kqa_pkg::request_t r);
        key_report_t   rep;
        kqa_pkg::key_t k;
        int            d;
        int            slot;
        bit            done;

        rep.key = kqa_pkg::KEY_NONE;
        d       = int'(r.device);
        case (r.operation)
            kqa_pkg::OP_RAW:
            begin
                if (r.event_type == kqa_pkg::EV_SYN && r.event_code == kqa_pkg::SYNC_OVERRUN)
                begin
                    // queue overflow: forget what is held and wait for a report
                    for (int i = 0; i < kqa_pkg::NKEYS; i++)
                        held_key[d][i] = 1'b0;
                    waiting_report[d] = 1'b1;
                end
                else if (waiting_report[d])
                begin
                    if (r.event_type == kqa_pkg::EV_SYN && r.event_code == kqa_pkg::SYNC_MARK)
                        waiting_report[d] = 1'b0;
                end
                else if (r.event_type == kqa_pkg::EV_KEY)
                begin
                    case (r.event_code)
                        kqa_pkg::CODE_UP:    k = kqa_pkg::KEY_UP;
                        kqa_pkg::CODE_DOWN:  k = kqa_pkg::KEY_DN;
                        kqa_pkg::CODE_LEFT:  k = kqa_pkg::KEY_LT;
                        kqa_pkg::CODE_RIGHT: k = kqa_pkg::KEY_RT;
                        kqa_pkg::CODE_OK_A,
                        kqa_pkg::CODE_OK_B:  k = kqa_pkg::KEY_OK;
                        kqa_pkg::CODE_BACK:  k = kqa_pkg::KEY_BACK;
                        default:             k = kqa_pkg::KEY_NONE;
                    endcase
                    if (k != kqa_pkg::KEY_NONE)
                    begin
                        slot = int'(k) - 1;
                        if (r.event_value == kqa_pkg::VAL_RELEASE)
                        begin
                            held_key[d][slot] = 1'b0;
                        end
                        else if (r.event_value == kqa_pkg::VAL_PRESS && !held_key[d][slot])
                        begin
                            held_key[d][slot] = 1'b1;
                            if (slot < kqa_pkg::NARROWS)
                                due_at_ms[d][slot] = rearm_time(r.now_ms);
                            rep.key = k;
                        end
                    end
                end
            end
            kqa_pkg::OP_TICK:
            begin
                // first due arrow in device-then-key order, no catch-up
                done = 1'b0;
                for (int dv = 0; dv < kqa_pkg::NUM_DEVICES; dv++)
                    for (int a = 0; a < kqa_pkg::NARROWS; a++)
                        if (!done && held_key[dv][a] && r.now_ms >= due_at_ms[dv][a])
                        begin
                            due_at_ms[dv][a] = rearm_time(r.now_ms);
                            rep.key = kqa_pkg::key_t'(a + 1);
                            done = 1'b1;
                        end
            end
            kqa_pkg::OP_RESUME:
            begin
                for (int dv = 0; dv < kqa_pkg::NUM_DEVICES; dv++)
                    for (int i = 0; i < kqa_pkg::NKEYS; i++)
                        held_key[dv][i] = 1'b0;
            end
            default: ;
        endcase

        // earliest armed arrow after this update, capped by the deadline
        rep.next_due = r.deadline_in;
        for (int dv = 0; dv < kqa_pkg::NUM_DEVICES; dv++)
            for (int a = 0; a < kqa_pkg::NARROWS; a++)
                if (held_key[dv][a] && due_at_ms[dv][a] < rep.next_due)
                    rep.next_due = due_at_ms[dv][a];
        return rep;
    endfunction

    function automatic dir_row_t row(input logic [1:0] op, input logic dev,
                                     input logic [15:0] typ, input logic [15:0] code,
                                     input logic [31:0] val, input logic [31:0] now,
                                     input logic [31:0] dl, input bit typed,
                                     input kqa_pkg::key_t key, input logic [31:0] due);
        dir_row_t t;
        t.req.operation   = op;
        t.req.device      = dev;
        t.req.event_type  = typ;
        t.req.event_code  = code;
        t.req.event_value = val;
        t.req.now_ms      = now;
        t.req.deadline_in = dl;
        t.typed           = typed;
        t.key             = key;
        t.due             = due;
        return t;
    endfunction

    task automatic report_failure(input string msg);
        fail_count++;
        $display("%0t ns: %s", $time, msg);
    endtask

    // Offer one request from a falling edge, hold it until the handshake, then
    // book the expected result. Returns on the next falling edge.
    task automatic offer_request(input kqa_pkg::request_t r, input bit typed,
                                 input kqa_pkg::key_t tkey, input logic [31:0] tdue);
        key_report_t rep;
        while ($urandom_range(99) < src_idle)
        begin
            evt_if.valid = 1'b0;
            @(negedge clk);
        end
        evt_if.operation   = r.operation;
        evt_if.device      = r.device;
        evt_if.event_type  = r.event_type;
        evt_if.event_code  = r.event_code;
        evt_if.event_value = r.event_value;
        evt_if.now_ms      = r.now_ms;
        evt_if.deadline_in = r.deadline_in;
        evt_if.valid       = 1'b1;
        do
            @(posedge clk);
        while (!evt_if.ready);
        rep = qualify_event(r);
        if (typed)
        begin
            rep.key      = tkey;
            rep.next_due = tdue;
        end
        key_reports_q.push_back(rep);
        @(negedge clk);
    endtask

    // Build a random request. The largest share of traffic is well-formed key
    // presses and releases on a slowly advancing clock, so that holds and repeats
    // build up; the rest is ticks, resumes, sync traffic and noise.
    task automatic random_request(output kqa_pkg::request_t r);
        int pick;
        int step_max;
        int sel;

        pick     = $urandom_range(99);
        step_max = int'(period_ms) + int'(period_ms) / 2 + 1;
        wall_ms  = wall_ms + $urandom_range(0, step_max);

        r.operation   = kqa_pkg::OP_RAW;
        r.device      = 1'($urandom_range(1));
        r.event_type  = 16'($urandom());
        r.event_code  = 16'($urandom());
        r.event_value = $urandom();

        sel = $urandom_range(39);
        if (sel == 0)
            r.now_ms = $urandom();
        else if (sel == 1)
            r.now_ms = kqa_pkg::TIME_MAX - $urandom_range(0, step_max);
        else
            r.now_ms = wall_ms;

        sel = $urandom_range(15);
        if (sel == 0)
            r.deadline_in = kqa_pkg::TIME_MAX;
        else if (sel < 3)
            r.deadline_in = $urandom();
        else
            r.deadline_in = wall_ms + $urandom_range(0, 3 * step_max);

        if (pick < 45)
        begin
            r.event_type = kqa_pkg::EV_KEY;
            r.event_code = KEY_CODES[$urandom_range(6)];
            sel = $urandom_range(19);
            if (sel < 11)
                r.event_value = kqa_pkg::VAL_PRESS;
            else if (sel < 19)
                r.event_value = kqa_pkg::VAL_RELEASE;
            else
                r.event_value = VAL_AUTOREPEAT;
        end
        else if (pick < 70)
        begin
            r.operation = kqa_pkg::OP_TICK;
        end
        else if (pick < 74)
        begin
            r.operation = kqa_pkg::OP_RESUME;
        end
        else if (pick < 77)
        begin
            r.operation = OP_UNUSED;
        end
        else if (pick < 87)
        begin
            r.event_type = kqa_pkg::EV_SYN;
            r.event_code = ($urandom_range(3) == 0) ? kqa_pkg::SYNC_OVERRUN
                                                    : kqa_pkg::SYNC_MARK;
        end
        else if ($urandom_range(1) == 0)
        begin
            // key type with a mostly unmapped code and an odd value
            r.event_type = kqa_pkg::EV_KEY;
        end
    endtask

    task automatic run_random(input int count);
        kqa_pkg::request_t r;
        for (int i = 0; i < count; i++)
        begin
            random_request(r);
            offer_request(r, 1'b0, kqa_pkg::KEY_NONE, 32'd0);
        end
    endtask

    // Let every owed result come back, then let the pipeline settle.
    task automatic drain_results();
        while (key_reports_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Write the repeat period only once the block has gone quiet.
    task automatic write_period(input logic [15:0] value);
        evt_if.valid = 1'b0;
        drain_results();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        period_ms   = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: give up well past the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: stall at random; when asked, hold off for a long stretch
    // so the pipeline fills and the request side has to wait.
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        hold_left    = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left    = HOLD_OFF_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_if.ready = 1'b0;
            end
            else
            begin
                res_if.ready = ($urandom_range(99) >= snk_idle);
            end
        end
    end

    // Compare every accepted result with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (key_reports_q.size() == 0)
            begin
                report_failure($sformatf("result with nothing owed: key_out %0d next_due_ms %0h",
                                         res_if.key_out, res_if.next_due_ms));
            end
            else
            begin
                want = key_reports_q.pop_front();
                if (res_if.key_out !== want.key)
                    report_failure($sformatf("key_out expected %0d, got %0d",
                                             want.key, res_if.key_out));
                if (res_if.next_due_ms !== want.next_due)
                    report_failure($sformatf("next_due_ms expected %0h, got %0h",
                                             want.next_due, res_if.next_due_ms));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t directed_rows [NDIR];

        // hold every input at a known value from time zero
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = 16'd0;
        evt_if.valid       = 1'b0;
        evt_if.operation   = kqa_pkg::OP_RAW;
        evt_if.device      = 1'b0;
        evt_if.event_type  = 16'd0;
        evt_if.event_code  = 16'd0;
        evt_if.event_value = 32'd0;
        evt_if.now_ms      = 32'd0;
        evt_if.deadline_in = 32'd0;
        for (int d = 0; d < kqa_pkg::NUM_DEVICES; d++)
        begin
            waiting_report[d] = 1'b0;
            for (int i = 0; i < kqa_pkg::NKEYS; i++)
                held_key[d][i] = 1'b0;
            for (int a = 0; a < kqa_pkg::NARROWS; a++)
                due_at_ms[d][a] = 32'd0;
        end

        // Directed requests against the reset period of 700 ms. Typed rows are
        // worked by hand; the others go through the predictor.
        directed_rows = '{
            // nothing held after reset: the deadline comes straight back
            row(kqa_pkg::OP_TICK, 1'b0, 16'd0, 16'd0, 32'd0, 32'd0, kqa_pkg::TIME_MAX,
                1'b1, kqa_pkg::KEY_NONE, kqa_pkg::TIME_MAX),
            // first press emits and arms 700 ms later
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_UP, kqa_pkg::VAL_PRESS,
                32'd1000, kqa_pkg::TIME_MAX, 1'b1, kqa_pkg::KEY_UP, 32'd1700),
            // press of a key already held
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_UP, kqa_pkg::VAL_PRESS,
                32'd1100, kqa_pkg::TIME_MAX, 1'b1, kqa_pkg::KEY_NONE, 32'd1700),
            // device-side autorepeat is ignored
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_UP, VAL_AUTOREPEAT,
                32'd1200, kqa_pkg::TIME_MAX, 1'b1, kqa_pkg::KEY_NONE, 32'd1700),
            // one millisecond early, then exactly due
            row(kqa_pkg::OP_TICK, 1'b0, 16'd0, 16'd0, 32'd0, 32'd1699, kqa_pkg::TIME_MAX,
                1'b1, kqa_pkg::KEY_NONE, 32'd1700),
            row(kqa_pkg::OP_TICK, 1'b0, 16'd0, 16'd0, 32'd0, 32'd1700, kqa_pkg::TIME_MAX,
                1'b1, kqa_pkg::KEY_UP, 32'd2400),
            // second device: an arrow under a tight deadline, both OK codes, back
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_KEY, kqa_pkg::CODE_RIGHT, kqa_pkg::VAL_PRESS,
                32'd2000, 32'd2100, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_KEY, kqa_pkg::CODE_OK_A, kqa_pkg::VAL_PRESS,
                32'd2000, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_KEY, kqa_pkg::CODE_OK_B, kqa_pkg::VAL_PRESS,
                32'd2010, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_KEY, kqa_pkg::CODE_BACK, kqa_pkg::VAL_PRESS,
                32'd2020, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            // unmapped code, unmapped type, out-of-range values
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, 16'hFFFF, kqa_pkg::VAL_PRESS,
                32'd2100, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b0, 16'hFFFF, kqa_pkg::CODE_DOWN, kqa_pkg::VAL_PRESS,
                32'd2100, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_DOWN, 32'h8000_0000,
                32'd2200, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_DOWN, 32'h7FFF_FFFF,
                32'd2200, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            // sync report with no overflow pending does nothing
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_SYN, kqa_pkg::SYNC_MARK, kqa_pkg::VAL_PRESS,
                32'd2500, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            // two arrows due at once: device order decides, one per tick
            row(kqa_pkg::OP_TICK, 1'b0, 16'd0, 16'd0, 32'd0, 32'd2700, kqa_pkg::TIME_MAX,
                1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_TICK, 1'b1, 16'd0, 16'd0, 32'd0, 32'd2700, kqa_pkg::TIME_MAX,
                1'b0, kqa_pkg::KEY_NONE, 32'd0),
            // overflow on device one: drop until a report
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_SYN, kqa_pkg::SYNC_OVERRUN, 32'd0,
                32'd2800, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_KEY, kqa_pkg::CODE_LEFT, kqa_pkg::VAL_PRESS,
                32'd2900, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_SYN, kqa_pkg::SYNC_MARK, 32'd0,
                32'd2950, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            row(kqa_pkg::OP_RAW, 1'b1, kqa_pkg::EV_KEY, kqa_pkg::CODE_LEFT, kqa_pkg::VAL_PRESS,
                32'd3000, kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            // unused operation with every field at its top
            row(OP_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, kqa_pkg::TIME_MAX,
                kqa_pkg::TIME_MAX, 1'b0, kqa_pkg::KEY_NONE, 32'd0),
            // resume clears every hold
            row(kqa_pkg::OP_RESUME, 1'b0, 16'd0, 16'd0, 32'd0, 32'd3100, 32'd5,
                1'b1, kqa_pkg::KEY_NONE, 32'd5),
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_UP, kqa_pkg::VAL_RELEASE,
                32'd3200, 32'd0, 1'b1, kqa_pkg::KEY_NONE, 32'd0),
            // arming near the top of the range saturates
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_DOWN, kqa_pkg::VAL_PRESS,
                32'hFFFF_FF00, 32'hFFFF_FFFE, 1'b1, kqa_pkg::KEY_DN, 32'hFFFF_FFFE),
            row(kqa_pkg::OP_TICK, 1'b0, 16'd0, 16'd0, 32'd0, kqa_pkg::TIME_MAX,
                kqa_pkg::TIME_MAX, 1'b1, kqa_pkg::KEY_DN, kqa_pkg::TIME_MAX),
            row(kqa_pkg::OP_RAW, 1'b0, kqa_pkg::EV_KEY, kqa_pkg::CODE_DOWN, kqa_pkg::VAL_RELEASE,
                kqa_pkg::TIME_MAX, 32'h1234_5678, 1'b1, kqa_pkg::KEY_NONE, 32'h1234_5678)
        };

        // reset once, released on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // sender idles lightly, receiver heavily
        src_idle = 15;
        snk_idle = 47;
        foreach (directed_rows[i])
            offer_request(directed_rows[i].req, directed_rows[i].typed,
                          directed_rows[i].key, directed_rows[i].due);

        // shortest period: holds fall due at almost every tick
        write_period(16'd1);
        run_random(300);

        // swap the idling sides; longest period
        src_idle = 47;
        snk_idle = 15;
        write_period(16'hFFFF);
        run_random(300);

        // zero period is taken as written
        write_period(16'd0);
        run_random(200);

        // no idling; hold the result side off so the request side backs up
        src_idle = 0;
        snk_idle = 0;
        write_period(16'($urandom_range(2, 5000)));
        hold_off_req = 1'b1;
        run_random(400);

        write_period(kqa_pkg::PERIOD_RESET);
        run_random(600);

        evt_if.valid = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/kqa_pkg.sv
sv/kqa_ifs.sv
sv/key_event_qualifier_autorepeat.sv
sv/kqa_checker.sv
tb/tb_key_event_qualifier_autorepeat.sv
